FILE: src/yfdtd_pkg.sv
// ----------------------------------------------------------------------------
// yfdtd_pkg - shared types and constants of the 2-D Yee field update
// Cell and result layouts, stage payloads and register indexes.
// ----------------------------------------------------------------------------
package yfdtd_pkg;

	localparam int MAX_ROW = 256;
	localparam int COL_W   = $clog2(MAX_ROW);
	localparam int LEN_W   = 9;
	localparam int COEF_W  = 31;
	localparam int VAL_W   = 32;
	localparam int PROD_W  = 64;
	localparam int LANES   = 7;
	localparam int IDX_W   = 3;

	// Register indexes of the configuration channel
	localparam logic [IDX_W-1:0] REG_PASS_KIND  = 3'd0;
	localparam logic [IDX_W-1:0] REG_ROW_LENGTH = 3'd1;
	localparam logic [IDX_W-1:0] REG_COEF_Y     = 3'd2;
	localparam logic [IDX_W-1:0] REG_COEF_Z     = 3'd3;
	localparam logic [IDX_W-1:0] REG_COEF_DT    = 3'd4;

	// Pass kinds
	localparam logic PASS_E = 1'b0;
	localparam logic PASS_H = 1'b1;

	typedef struct packed {
		logic signed [VAL_W-1:0] j_z;
		logic signed [VAL_W-1:0] j_y;
		logic signed [VAL_W-1:0] j_x;
		logic signed [VAL_W-1:0] h_z;
		logic signed [VAL_W-1:0] h_y;
		logic signed [VAL_W-1:0] h_x;
		logic signed [VAL_W-1:0] e_z;
		logic signed [VAL_W-1:0] e_y;
		logic signed [VAL_W-1:0] e_x;
	} cell_t;

	// Neighbour words fetched for one cell: line store (z-1 / z+1) and
	// previous cell (y-1 / y+1), plus the edge flag and pass kind at accept.
	typedef struct packed {
		logic [2*VAL_W-1:0] up;
		logic [2*VAL_W-1:0] prev;
		logic               at_edge;
		logic               mode;
	} nbr_t;

	typedef struct packed {
		logic [LANES-1:0][PROD_W-1:0] prod;
		logic signed [VAL_W-1:0]      base_x;
		logic signed [VAL_W-1:0]      base_y;
		logic signed [VAL_W-1:0]      base_z;
		logic                         at_edge;
		logic                         mode;
		logic                         last;
	} prod_t;

	typedef struct packed {
		logic                    end_out;
		logic signed [VAL_W-1:0] new_z;
		logic signed [VAL_W-1:0] new_y;
		logic signed [VAL_W-1:0] new_x;
	} res_t;

	typedef struct packed {
		logic              pass_kind;
		logic [LEN_W-1:0]  row_length;
		logic [COEF_W-1:0] coef_y;
		logic [COEF_W-1:0] coef_z;
		logic [COEF_W-1:0] coef_dt;
	} cfg_t;

endpackage

FILE: src/yfdtd_stencil_ctl.sv
// ----------------------------------------------------------------------------
// yfdtd_stencil_ctl - stream position, previous cell and line store
// Tracks column and first row, fetches the neighbour words of each accepted
// cell and stores this cell's words for the next cell and the next row.
// ----------------------------------------------------------------------------
module yfdtd_stencil_ctl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic                 last,
	input  yfdtd_pkg::cell_t     cell_in,
	input  yfdtd_pkg::cfg_t      cfg,
	output yfdtd_pkg::nbr_t      nbr_s1
);

	logic [yfdtd_pkg::COL_W-1:0]     col_q;
	logic                            first_row_q;
	logic [2*yfdtd_pkg::VAL_W-1:0]   prev_q;
	logic [2*yfdtd_pkg::VAL_W-1:0]   mem [yfdtd_pkg::MAX_ROW];
	logic [2*yfdtd_pkg::VAL_W-1:0]   up_s1;
	logic [2*yfdtd_pkg::VAL_W-1:0]   prev_s1;
	logic                            edge_s1;
	logic                            mode_s1;
	logic [yfdtd_pkg::LEN_W-1:0]     eff_len;
	logic [yfdtd_pkg::LEN_W-1:0]     col_inc;
	logic [2*yfdtd_pkg::VAL_W-1:0]   prev_wr;
	logic [2*yfdtd_pkg::VAL_W-1:0]   line_wr;

	// clamp the row length to 2..MAX_ROW
	always_comb begin
		if (cfg.row_length < yfdtd_pkg::LEN_W'(2)) begin
			eff_len = yfdtd_pkg::LEN_W'(2);
		end else if (cfg.row_length > yfdtd_pkg::LEN_W'(yfdtd_pkg::MAX_ROW)) begin
			eff_len = yfdtd_pkg::LEN_W'(yfdtd_pkg::MAX_ROW);
		end else begin
			eff_len = cfg.row_length;
		end
	end

	assign col_inc = {1'b0, col_q} + yfdtd_pkg::LEN_W'(1);

	// E pass keeps H words, H pass keeps E words
	always_comb begin
		if (cfg.pass_kind == yfdtd_pkg::PASS_E) begin
			prev_wr = {cell_in.h_z, cell_in.h_x};
			line_wr = {cell_in.h_y, cell_in.h_x};
		end else begin
			prev_wr = {cell_in.e_z, cell_in.e_x};
			line_wr = {cell_in.e_y, cell_in.e_x};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			first_row_q <= 1'b1;
			prev_q      <= '0;
		end else if (accept) begin
			prev_q <= prev_wr;
			if (last) begin
				col_q       <= '0;
				first_row_q <= 1'b1;
			end else if (col_inc >= eff_len) begin
				col_q       <= '0;
				first_row_q <= 1'b0;
			end else begin
				col_q <= col_inc[yfdtd_pkg::COL_W-1:0];
			end
		end
	end

	// read the old row entry and overwrite it in the same cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			up_s1      <= mem[col_q];
			mem[col_q] <= line_wr;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prev_s1 <= prev_q;
			edge_s1 <= (col_q == '0) || first_row_q;
			mode_s1 <= cfg.pass_kind;
		end
	end

	assign nbr_s1.up      = up_s1;
	assign nbr_s1.prev    = prev_s1;
	assign nbr_s1.at_edge = edge_s1;
	assign nbr_s1.mode    = mode_s1;

endmodule

FILE: src/yfdtd_mul_stage.sv
// ----------------------------------------------------------------------------
// yfdtd_mul_stage - difference and coefficient product lanes
// Forms the seven stencil differences, multiplies each by its coefficient
// and registers the exact products.
// ----------------------------------------------------------------------------
module yfdtd_mul_stage (
	input  logic                clk,
	input  logic                en,
	input  yfdtd_pkg::cell_t    cell_s1,
	input  logic                last_s1,
	input  yfdtd_pkg::nbr_t     nbr_s1,
	input  yfdtd_pkg::cfg_t     cfg,
	output yfdtd_pkg::prod_t    prod_s2
);

	logic signed [yfdtd_pkg::VAL_W:0]    d    [yfdtd_pkg::LANES];
	logic signed [yfdtd_pkg::VAL_W-1:0]  c    [yfdtd_pkg::LANES];
	logic signed [yfdtd_pkg::PROD_W-1:0] p    [yfdtd_pkg::LANES];
	logic signed [yfdtd_pkg::VAL_W:0]    up_lo, up_hi, pv_lo, pv_hi;
	logic [yfdtd_pkg::COEF_W-1:0]        cdt;
	yfdtd_pkg::prod_t                    nxt;

	// sign-extend helper words to 33 bits
	function automatic logic signed [yfdtd_pkg::VAL_W:0] sx(
		input logic [yfdtd_pkg::VAL_W-1:0] v);
		sx = {v[yfdtd_pkg::VAL_W-1], v};
	endfunction

	always_comb begin
		up_lo = sx(nbr_s1.up[yfdtd_pkg::VAL_W-1:0]);
		up_hi = sx(nbr_s1.up[2*yfdtd_pkg::VAL_W-1:yfdtd_pkg::VAL_W]);
		pv_lo = sx(nbr_s1.prev[yfdtd_pkg::VAL_W-1:0]);
		pv_hi = sx(nbr_s1.prev[2*yfdtd_pkg::VAL_W-1:yfdtd_pkg::VAL_W]);
		cdt   = (nbr_s1.mode == yfdtd_pkg::PASS_E) ? cfg.coef_dt : '0;

		if (nbr_s1.mode == yfdtd_pkg::PASS_E) begin
			d[0] = sx(cell_s1.h_z) - pv_hi;
			d[1] = sx(cell_s1.h_y) - up_hi;
			d[2] = sx(cell_s1.j_x);
			d[3] = sx(cell_s1.h_x) - up_lo;
			d[4] = sx(cell_s1.j_y);
			d[5] = sx(cell_s1.h_x) - pv_lo;
			d[6] = sx(cell_s1.j_z);
		end else begin
			d[0] = pv_hi - sx(cell_s1.e_z);
			d[1] = up_hi - sx(cell_s1.e_y);
			d[2] = '0;
			d[3] = up_lo - sx(cell_s1.e_x);
			d[4] = '0;
			d[5] = pv_lo - sx(cell_s1.e_x);
			d[6] = '0;
		end

		c[0] = $signed({1'b0, cfg.coef_y});
		c[1] = $signed({1'b0, cfg.coef_z});
		c[2] = $signed({1'b0, cdt});
		c[3] = $signed({1'b0, cfg.coef_z});
		c[4] = $signed({1'b0, cdt});
		c[5] = $signed({1'b0, cfg.coef_y});
		c[6] = $signed({1'b0, cdt});

		for (int i = 0; i < yfdtd_pkg::LANES; i++) begin
			p[i] = c[i] * d[i];
		end

		for (int i = 0; i < yfdtd_pkg::LANES; i++) begin
			nxt.prod[i] = p[i];
		end
		if (nbr_s1.mode == yfdtd_pkg::PASS_E) begin
			nxt.base_x = cell_s1.e_x;
			nxt.base_y = cell_s1.e_y;
			nxt.base_z = cell_s1.e_z;
		end else begin
			nxt.base_x = cell_s1.h_x;
			nxt.base_y = cell_s1.h_y;
			nxt.base_z = cell_s1.h_z;
		end
		nxt.at_edge = nbr_s1.at_edge;
		nxt.mode    = nbr_s1.mode;
		nxt.last    = last_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= nxt;
		end
	end

endmodule

FILE: src/yfdtd_sum_stage.sv
// ----------------------------------------------------------------------------
// yfdtd_sum_stage - rounding, summation and saturation
// Rounds each product to Q16.16, adds the terms to the field and saturates
// into the result register.
// ----------------------------------------------------------------------------
module yfdtd_sum_stage (
	input  logic              clk,
	input  logic              en,
	input  yfdtd_pkg::prod_t  prod_s2,
	output yfdtd_pkg::res_t   res_s3
);

	localparam int R_W = 34;
	localparam int S_W = 37;

	logic signed [R_W-1:0]              r [yfdtd_pkg::LANES];
	logic signed [yfdtd_pkg::PROD_W-1:0] t;
	logic signed [S_W-1:0]              sum_x, sum_y, sum_z;
	yfdtd_pkg::res_t                    nxt;

	function automatic logic signed [S_W-1:0] ext_r(input logic signed [R_W-1:0] v);
		ext_r = S_W'(v);
	endfunction

	function automatic logic signed [S_W-1:0] ext_b(
		input logic signed [yfdtd_pkg::VAL_W-1:0] v);
		ext_b = S_W'(v);
	endfunction

	function automatic logic signed [yfdtd_pkg::VAL_W-1:0] sat(
		input logic signed [S_W-1:0] v);
		if (v > ext_b(32'sh7FFF_FFFF)) begin
			sat = 32'sh7FFF_FFFF;
		end else if (v < ext_b(32'sh8000_0000)) begin
			sat = 32'sh8000_0000;
		end else begin
			sat = v[yfdtd_pkg::VAL_W-1:0];
		end
	endfunction

	always_comb begin
		t = '0;
		// add half an output step, then floor-shift by 30
		for (int i = 0; i < yfdtd_pkg::LANES; i++) begin
			t    = $signed(prod_s2.prod[i]) + 64'sd536870912;
			r[i] = t[yfdtd_pkg::PROD_W-1:30];
		end

		if (prod_s2.mode == yfdtd_pkg::PASS_E) begin
			sum_x = ext_b(prod_s2.base_x) + ext_r(r[0]) - ext_r(r[1]) - ext_r(r[2]);
			sum_y = ext_b(prod_s2.base_y) + ext_r(r[3]) - ext_r(r[4]);
			sum_z = ext_b(prod_s2.base_z) - ext_r(r[5]) - ext_r(r[6]);
		end else begin
			sum_x = ext_b(prod_s2.base_x) - ext_r(r[0]) + ext_r(r[1]) - ext_r(r[2]);
			sum_y = ext_b(prod_s2.base_y) - ext_r(r[3]) - ext_r(r[4]);
			sum_z = ext_b(prod_s2.base_z) + ext_r(r[5]) - ext_r(r[6]);
		end

		// edge cells pass through unchanged
		if (prod_s2.at_edge) begin
			nxt.new_x = prod_s2.base_x;
			nxt.new_y = prod_s2.base_y;
			nxt.new_z = prod_s2.base_z;
		end else begin
			nxt.new_x = sat(sum_x);
			nxt.new_y = sat(sum_y);
			nxt.new_z = sat(sum_z);
		end
		nxt.end_out = prod_s2.last;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s3 <= nxt;
		end
	end

endmodule

FILE: src/yee_fdtd_field_update_2d.sv
// ----------------------------------------------------------------------------
// yee_fdtd_field_update_2d - streaming 2-D Yee field update (y-z plane)
// Top level: stream handshake, configuration registers and the three-stage
// pipeline of stencil fetch, product lanes and rounded summation.
// ----------------------------------------------------------------------------
// The block takes one cell per clock while s_tready is high and returns one
// result word per cell, after the stage 1, 2 and 3 registers in turn.
// Stage 1 registers the cell and fetches its neighbours: the previous cell
// from a register and the previous row from a 256 x 64 line store with one
// read and one write per cell. Stage 2 holds the seven coefficient products,
// stage 3 the rounded, summed and saturated result. The three stages hold up
// to three words in flight, so input words are still taken while a result
// waits at the output. Cells stream in raster order, y fastest; pass_kind 1
// (H update) expects the plane in reverse order. Cells on the first row or
// column of a plane are returned unchanged, and tlast on an input word ends
// the plane and rewinds the stream position. The line store is not cleared
// after reset; a well-formed plane writes each entry before using a value
// read from it. Write configuration only while no words are in flight.
// ----------------------------------------------------------------------------
module yee_fdtd_field_update_2d (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// input cells
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// e_x, e_y, e_z, h_x, h_y, h_z, j_x, j_y, j_z (low to high)
	input  logic [9*yfdtd_pkg::VAL_W-1:0]          s_tdata,
	input  logic                                   s_tlast,   // grid_end
	// results
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// new_x, new_y, new_z (low to high)
	output logic [3*yfdtd_pkg::VAL_W-1:0]          m_tdata,
	output logic                                   m_tlast,   // end_out
	// configuration writes
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [yfdtd_pkg::IDX_W-1:0]            cfg_index,
	input  logic [yfdtd_pkg::COEF_W-1:0]           cfg_data
);

	yfdtd_pkg::cfg_t   cfg_q;
	yfdtd_pkg::cell_t  cell_s1;
	logic              last_s1;
	yfdtd_pkg::nbr_t   nbr_s1;
	yfdtd_pkg::prod_t  prod_s2;
	yfdtd_pkg::res_t   res_s3;
	logic              vld_s1, vld_s2, vld_s3;
	logic              adv1, adv2, adv3;
	logic              in_acc;

	// advance a stage when it is empty or its successor is moving
	assign adv3     = !vld_s3 || m_tready;
	assign adv2     = !vld_s2 || adv3;
	assign adv1     = !vld_s1 || adv2;
	assign s_tready = adv1;
	assign in_acc   = s_tvalid && adv1;

	assign cfg_ready = 1'b1;

	// configuration registers; writes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pass_kind  <= yfdtd_pkg::PASS_E;
			cfg_q.row_length <= yfdtd_pkg::LEN_W'(yfdtd_pkg::MAX_ROW);
			cfg_q.coef_y     <= '0;
			cfg_q.coef_z     <= '0;
			cfg_q.coef_dt    <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				yfdtd_pkg::REG_PASS_KIND:  cfg_q.pass_kind  <= cfg_data[0];
				yfdtd_pkg::REG_ROW_LENGTH: cfg_q.row_length <= cfg_data[yfdtd_pkg::LEN_W-1:0];
				yfdtd_pkg::REG_COEF_Y:     cfg_q.coef_y     <= cfg_data;
				yfdtd_pkg::REG_COEF_Z:     cfg_q.coef_z     <= cfg_data;
				yfdtd_pkg::REG_COEF_DT:    cfg_q.coef_dt    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (adv1) begin
				vld_s1 <= s_tvalid;
			end
			if (adv2) begin
				vld_s2 <= vld_s1;
			end
			if (adv3) begin
				vld_s3 <= vld_s2;
			end
		end
	end

	// input register; hold the cell while stage 1 is stalled
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cell_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	yfdtd_stencil_ctl u_ctl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (in_acc),
		.last    (s_tlast),
		.cell_in (yfdtd_pkg::cell_t'(s_tdata)),
		.cfg     (cfg_q),
		.nbr_s1  (nbr_s1)
	);

	yfdtd_mul_stage u_mul (
		.clk     (clk),
		.en      (adv2),
		.cell_s1 (cell_s1),
		.last_s1 (last_s1),
		.nbr_s1  (nbr_s1),
		.cfg     (cfg_q),
		.prod_s2 (prod_s2)
	);

	yfdtd_sum_stage u_sum (
		.clk     (clk),
		.en      (adv3),
		.prod_s2 (prod_s2),
		.res_s3  (res_s3)
	);

	assign m_tvalid = vld_s3;
	assign m_tdata  = {res_s3.new_z, res_s3.new_y, res_s3.new_x};
	assign m_tlast  = res_s3.end_out;

endmodule

FILE: src/yfdtd_checker.sv
// ----------------------------------------------------------------------------
// yfdtd_checker - port-level checks of the field update block
// Tracks words in flight and checks ordering and flow control at the ports.
// ----------------------------------------------------------------------------
module yfdtd_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	input  logic                              s_tready,
	input  logic                              m_tvalid,
	input  logic                              m_tready,
	input  logic [3*yfdtd_pkg::VAL_W-1:0]     m_tdata,
	input  logic                              m_tlast
);

	localparam logic [1:0] DEPTH = 2'd3;

	logic [1:0] cnt_q;
	logic       in_acc, out_acc;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	// words accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= 2'(cnt_q + {1'b0, in_acc} - {1'b0, out_acc});
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result word changed while stalled");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> cnt_q != 2'd0)
		else $error("result word without an accepted cell");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == DEPTH) && !m_tready |-> !s_tready)
		else $error("cell taken with the pipeline full and stalled");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd0 |-> s_tready && !m_tvalid)
		else $error("empty pipeline refuses cells or shows a result");

endmodule

bind yee_fdtd_field_update_2d yfdtd_checker u_yfdtd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

FILE: test/yee_update_checker.sv
// ----------------------------------------------------------------------------
// yee_update_checker - result checker for the 2-D Yee field update
// Watches the cell, result and configuration channels and keeps its own copy
// of the registers, the line store and the stream position. It works out the
// updated fields of every accepted cell and compares each result word with
// the oldest one still waiting.
// ----------------------------------------------------------------------------
module yee_update_checker
	import yfdtd_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	input  logic                     s_tready,
	input  logic [9*VAL_W-1:0]       s_tdata,
	input  logic                     s_tlast,
	input  logic                     m_tvalid,
	input  logic                     m_tready,
	input  logic [3*VAL_W-1:0]       m_tdata,
	input  logic                     m_tlast,
	input  logic                     cfg_valid,
	input  logic                     cfg_ready,
	input  logic [IDX_W-1:0]         cfg_index,
	input  logic [COEF_W-1:0]        cfg_data,
	output int                       errors,
	output int                       pending
);

	localparam int MAX_PRINTS = 30;

	// register copy
	logic               mode;
	logic [LEN_W-1:0]   row_len;
	logic [COEF_W-1:0]  k_y;
	logic [COEF_W-1:0]  k_z;
	logic [COEF_W-1:0]  k_dt;

	// stencil state: previous row per column, previous streamed cell, position
	logic [2*VAL_W-1:0] row_mem [MAX_ROW];
	logic [2*VAL_W-1:0] last_cell;
	int unsigned        col_pos;
	logic               top_row;

	res_t               updated_q [$];

	task automatic report(string what, logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
		if (errors < MAX_PRINTS)
			$display("%0t mismatch: %s got %h want %h", $realtime, what, got, want);
		errors++;
	endtask

	function automatic longint word_s(logic [VAL_W-1:0] w);
		return longint'($signed(w));
	endfunction

	// coefficient times value, rounded half up to Q16.16
	function automatic longint q30_term(logic [COEF_W-1:0] k, longint d);
		longint p;
		p = longint'({1'b0, k}) * d + (longint'(1) <<< 29);
		return p >>> 30;
	endfunction

	function automatic logic [VAL_W-1:0] clip(longint v);
		if (v > 64'sd2147483647)
			return 32'h7FFF_FFFF;
		if (v < -64'sd2147483648)
			return 32'h8000_0000;
		return v[VAL_W-1:0];
	endfunction

	function automatic res_t field_update(cell_t c, logic last_in);
		res_t               r;
		int unsigned        len;
		logic               at_rim;
		logic [2*VAL_W-1:0] above;
		longint             nx;
		longint             ny;
		longint             nz;
		len = row_len;
		if (len < 2)
			len = 2;
		if (len > MAX_ROW)
			len = MAX_ROW;
		at_rim = (col_pos == 0) || top_row;
		above = top_row ? '0 : row_mem[col_pos];
		if (mode == PASS_E) begin
			nx = word_s(c.e_x);
			ny = word_s(c.e_y);
			nz = word_s(c.e_z);
			if (!at_rim) begin
				nx = nx + q30_term(k_y, word_s(c.h_z) - word_s(last_cell[63:32]))
					- q30_term(k_z, word_s(c.h_y) - word_s(above[63:32]))
					- q30_term(k_dt, word_s(c.j_x));
				ny = ny + q30_term(k_z, word_s(c.h_x) - word_s(above[31:0]))
					- q30_term(k_dt, word_s(c.j_y));
				nz = nz - q30_term(k_y, word_s(c.h_x) - word_s(last_cell[31:0]))
					- q30_term(k_dt, word_s(c.j_z));
			end
			last_cell = {c.h_z, c.h_x};
			row_mem[col_pos] = {c.h_y, c.h_x};
		end else begin
			nx = word_s(c.h_x);
			ny = word_s(c.h_y);
			nz = word_s(c.h_z);
			if (!at_rim) begin
				nx = nx - q30_term(k_y, word_s(last_cell[63:32]) - word_s(c.e_z))
					+ q30_term(k_z, word_s(above[63:32]) - word_s(c.e_y));
				ny = ny - q30_term(k_z, word_s(above[31:0]) - word_s(c.e_x));
				nz = nz + q30_term(k_y, word_s(last_cell[31:0]) - word_s(c.e_x));
			end
			last_cell = {c.e_z, c.e_x};
			row_mem[col_pos] = {c.e_y, c.e_x};
		end
		r.new_x = clip(nx);
		r.new_y = clip(ny);
		r.new_z = clip(nz);
		r.end_out = last_in;
		// rewind on plane end, wrap at the end of a row
		if (last_in) begin
			col_pos = 0;
			top_row = 1'b1;
		end else if (col_pos + 1 >= len) begin
			col_pos = 0;
			top_row = 1'b0;
		end else begin
			col_pos = col_pos + 1;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t got;
		res_t want;
		if (!arst_n) begin
			mode = PASS_E;
			row_len = 9'd256;
			k_y = '0;
			k_z = '0;
			k_dt = '0;
			last_cell = '0;
			col_pos = 0;
			top_row = 1'b1;
			updated_q.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_PASS_KIND:  mode = cfg_data[0];
					REG_ROW_LENGTH: row_len = cfg_data[LEN_W-1:0];
					REG_COEF_Y:     k_y = cfg_data;
					REG_COEF_Z:     k_z = cfg_data;
					REG_COEF_DT:    k_dt = cfg_data;
					default: ;
				endcase
			end
			// check results before taking new cells: no cell leaves on its own edge
			if (m_tvalid && m_tready) begin
				got = {m_tlast, m_tdata};
				if (updated_q.size() == 0) begin
					report("result word with no cell waiting", got.new_x, '0);
				end else begin
					want = updated_q.pop_front();
					if (got.new_x !== want.new_x)
						report("new_x", got.new_x, want.new_x);
					if (got.new_y !== want.new_y)
						report("new_y", got.new_y, want.new_y);
					if (got.new_z !== want.new_z)
						report("new_z", got.new_z, want.new_z);
					if (got.end_out !== want.end_out)
						report("end_out", 32'(got.end_out), 32'(want.end_out));
				end
			end
			if (s_tvalid && s_tready)
				updated_q.push_back(field_update(s_tdata, s_tlast));
			pending = updated_q.size();
		end
	end

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - testbench top for the 2-D Yee field update
// Drives cells and register writes into the block, stalls the result side at
// random and leaves all prediction and comparison to the checker beside it.
// A short directed part hits reset settings, saturation both ways, rounding
// ties, clamped row lengths and ignored register indexes; random planes in
// both field passes follow, with one plane on the longest row.
// ----------------------------------------------------------------------------
module tb_top;
	import yfdtd_pkg::*;

	localparam int              ITEMS     = 600;       // random cells to send
	localparam int              CALM_TAIL = 80;        // last cells sent with no idling
	localparam int              LIMIT     = 200000;    // watchdog, in clock cycles
	localparam logic [VAL_W-1:0] VMAX     = 32'h7FFF_FFFF;
	localparam logic [VAL_W-1:0] VMIN     = 32'h8000_0000;
	localparam logic [COEF_W-1:0] KMAX    = 31'h7FFF_FFFF;
	localparam logic [COEF_W-1:0] KHALF   = 31'h2000_0000;  // 0.5 in Q1.30
	localparam logic [COEF_W-1:0] KONE    = 31'h4000_0000;  // 1.0 in Q1.30

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [9*VAL_W-1:0]     s_tdata;     // e_x, e_y, e_z, h_x, h_y, h_z, j_x, j_y, j_z
	logic                   s_tlast;     // grid_end
	logic                   m_tvalid;
	logic                   m_tready;
	logic [3*VAL_W-1:0]     m_tdata;     // new_x, new_y, new_z
	logic                   m_tlast;     // end_out
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [IDX_W-1:0]       cfg_index;
	logic [COEF_W-1:0]      cfg_data;

	int                     errors;
	int                     pending;
	logic                   calm;        // no idling on either side once set
	int                     cycle_count;
	int                     cells_sent;
	int                     planes_sent;
	int                     reg_writes;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	yee_fdtd_field_update_2d u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	yee_update_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending)
	);

	// Field value: extremes now and then, otherwise full range or, in a
	// narrow phase, small values so that rounding ties and unsaturated sums
	// turn up often.
	function automatic logic [VAL_W-1:0] pick_val(logic narrow);
		case ($urandom_range(0, 9))
			0:       return VMAX;
			1:       return VMIN;
			2, 3:    return $urandom;
			default: return narrow ? 32'($urandom_range(0, 64)) - 32'd32 : $urandom;
		endcase
	endfunction

	function automatic logic [COEF_W-1:0] pick_coef();
		case ($urandom_range(0, 6))
			0:       return '0;
			1:       return KMAX;
			2:       return KHALF;
			3:       return KONE;
			4:       return 31'($urandom_range(0, 32'h0FFF_FFFF));
			default: return 31'($urandom);
		endcase
	endfunction

	// Present one register write and hold it until the channel takes it.
	// Leave cfg_valid high; the caller drops it after the last write.
	task automatic write_reg(logic [IDX_W-1:0] idx, logic [COEF_W-1:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		reg_writes++;
	endtask

	// Drop valid and wait until every result word has left the block.
	task automatic wait_drained();
		s_tvalid = 1'b0;
		cfg_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	// Offer one cell, at times after a random idle burst, and hold it
	// until it is taken. Valid stays high so the next cell can follow at once.
	task automatic push_cell(logic [8:0][VAL_W-1:0] w, logic last);
		calm = (cells_sent >= ITEMS + 23 - CALM_TAIL);
		if (!calm && $urandom_range(0, 5) == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 17))
				@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = w;
		s_tlast  = last;
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
		cells_sent++;
		if (last)
			planes_sent++;
	endtask

	// Result side: hold tready low in random bursts between ready stretches
	// of random length; stay ready once the tail is calm.
	initial begin
		int hold;
		hold = 0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (calm) begin
				m_tready = 1'b1;
				hold = 0;
			end else if (hold > 0) begin
				hold--;
			end else if ($urandom_range(0, 3) == 0) begin
				m_tready = 1'b0;
				hold = $urandom_range(1, 17) - 1;
			end else begin
				m_tready = 1'b1;
				hold = $urandom_range(0, 30);
			end
		end
	end

	// Watchdog: end a hung run.
	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		logic [8:0][VAL_W-1:0] w;
		logic                  mode_now;
		logic                  narrow;
		logic                  big_done;
		logic                  big_now;
		logic [LEN_W-1:0]      row_reg;
		logic [COEF_W-1:0]     d;
		int                    row_eff;
		int                    n_planes;
		int                    plane_len;
		int                    phase;

		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tlast   = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_PASS_KIND;
		cfg_data  = '0;
		calm      = 1'b0;
		cells_sent = 0;
		planes_sent = 0;
		reg_writes = 0;
		big_done  = 1'b0;
		arst_n    = 1'b0;
		repeat (4)
			@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// ---- directed part ----
		// Reset settings: E pass, zero coefficients, every cell on the first
		// row of a 256 long row, so the electric fields come straight back.
		for (int k = 0; k < 3; k++) begin
			for (int i = 0; i < 9; i++)
				w[i] = (k == 0) ? 32'hFFFF_FFFF : (k == 1) ? VMIN : VMAX;
			push_cell(w, k == 2);
		end

		// E pass, row length written as 0 (clamps to 2), full-scale
		// coefficients and alternating extreme fields: saturate both ways.
		wait_drained();
		write_reg(REG_PASS_KIND, 31'(PASS_E));
		write_reg(REG_ROW_LENGTH, '0);
		write_reg(REG_COEF_Y, KMAX);
		write_reg(REG_COEF_Z, KMAX);
		write_reg(REG_COEF_DT, KMAX);
		// indexes past the register list must be ignored
		for (int i = REG_COEF_DT + 1; i < (1 << IDX_W); i++)
			write_reg(IDX_W'(i), 31'($urandom));
		cfg_valid = 1'b0;
		for (int k = 0; k < 8; k++) begin
			// fields 0-2 electric, 3-5 magnetic, 6-8 current
			for (int i = 0; i < 9; i++)
				w[i] = (i < 3) ? (k[0] ? VMAX : VMIN) :
					(i < 6) ? (k[0] ? VMIN : VMAX) : (k[1] ? VMAX : VMIN);
			push_cell(w, k == 7);
		end

		// H pass, row length 1 (clamps to 2), half and unit coefficients on
		// small values: rounding ties land on both signs.
		wait_drained();
		write_reg(REG_PASS_KIND, 31'(PASS_H));
		write_reg(REG_ROW_LENGTH, 31'd1);
		write_reg(REG_COEF_Y, KHALF);
		write_reg(REG_COEF_Z, KONE);
		cfg_valid = 1'b0;
		for (int k = 0; k < 6; k++) begin
			for (int i = 0; i < 9; i++)
				w[i] = 32'($urandom_range(0, 6)) - 32'd3;
			push_cell(w, k == 5);
		end

		// E pass, row length 3 with junk above the 9 register bits, all
		// coefficients one half: ties through the current term as well.
		wait_drained();
		write_reg(REG_PASS_KIND, 31'(PASS_E));
		write_reg(REG_ROW_LENGTH, {22'h3F_FFFF, 9'd3});
		write_reg(REG_COEF_Y, KHALF);
		write_reg(REG_COEF_Z, KHALF);
		write_reg(REG_COEF_DT, KHALF);
		cfg_valid = 1'b0;
		for (int k = 0; k < 6; k++) begin
			for (int i = 0; i < 9; i++)
				w[i] = 32'($urandom_range(0, 6)) - 32'd3;
			push_cell(w, k == 5);
		end

		// ---- random part ----
		// Each phase: drain, write a fresh set of registers, then stream a few
		// well-formed planes, each closed by tlast so that the line store is
		// always filled by the plane that reads it.
		phase = 0;
		while (cells_sent < ITEMS + 23) begin
			wait_drained();
			mode_now = 1'($urandom_range(0, 1));
			d = 31'($urandom);
			d[0] = mode_now;
			write_reg(REG_PASS_KIND, d);

			big_now = !big_done && (phase == 4 || cells_sent > ITEMS / 2);
			if (big_now) begin
				big_done = 1'b1;
				row_reg = $urandom_range(0, 1) ? 9'd256 : 9'($urandom_range(257, 511));
			end else if ($urandom_range(0, 7) == 0) begin
				row_reg = 9'($urandom_range(0, 2));
			end else begin
				row_reg = 9'($urandom_range(3, 12));
			end
			row_eff = (row_reg < 2) ? 2 : (row_reg > MAX_ROW) ? MAX_ROW : row_reg;
			write_reg(REG_ROW_LENGTH, {22'($urandom), row_reg});
			write_reg(REG_COEF_Y, pick_coef());
			write_reg(REG_COEF_Z, pick_coef());
			write_reg(REG_COEF_DT, pick_coef());
			if ($urandom_range(0, 3) == 0)
				write_reg(IDX_W'($urandom_range(REG_COEF_DT + 1, (1 << IDX_W) - 1)),
					31'($urandom));
			cfg_valid = 1'b0;

			narrow = 1'($urandom_range(0, 1));
			n_planes = big_now ? 1 : $urandom_range(1, 3);
			for (int p = 0; p < n_planes; p++) begin
				if (big_now)
					plane_len = row_eff + $urandom_range(4, 40);
				else if ($urandom_range(0, 7) == 0)
					plane_len = $urandom_range(1, row_eff);
				else
					plane_len = row_eff * $urandom_range(2, 4) + $urandom_range(0, row_eff - 1);
				for (int n = 0; n < plane_len; n++) begin
					for (int i = 0; i < 9; i++)
						w[i] = pick_val(narrow);
					push_cell(w, n == plane_len - 1);
					// now and then stop mid-plane until the pipeline is empty
					if (!calm && $urandom_range(0, 80) == 0)
						wait_drained();
				end
			end
			phase++;
		end

		// ---- wind down ----
		s_tvalid = 1'b0;
		calm = 1'b1;
		while (pending != 0)
			@(negedge clk);
		repeat (10)
			@(negedge clk);

		$display("Covered %0d cells in %0d planes with %0d register writes,", cells_sent,
			planes_sent, reg_writes);
		$display("both field passes, row lengths clamped from 2 up to %0d.", MAX_ROW);
		if (errors == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
